// ===== hw/rtl/btndb_pkg.sv =====
// Shared types and event codes for the two-button debounce block.
// No dependencies; imported by every module of the block.
package btndb_pkg;

   // Widths of the item fields and configuration registers
   localparam int TIME_W = 32;
   localparam int CSR_W  = 16;
   localparam int EVENT_W = 3;

   // Configuration register indexes
   localparam logic CSR_DEBOUNCE_HOLD = 1'b0;
   localparam logic CSR_LONG_PRESS    = 1'b1;

   // Reset values of the configuration registers
   localparam logic [CSR_W-1:0] DEBOUNCE_HOLD_RESET = 16'd50;
   localparam logic [CSR_W-1:0] LONG_PRESS_RESET    = 16'd1000;

   // Event codes
   localparam logic [EVENT_W-1:0] EV_NONE         = 3'd0;
   localparam logic [EVENT_W-1:0] EV_SEL_PRESS    = 3'd1;
   localparam logic [EVENT_W-1:0] EV_SEL_RELEASE  = 3'd2;
   localparam logic [EVENT_W-1:0] EV_SEL_LONG     = 3'd3;
   localparam logic [EVENT_W-1:0] EV_BACK_PRESS   = 3'd4;
   localparam logic [EVENT_W-1:0] EV_BACK_RELEASE = 3'd5;
   localparam logic [EVENT_W-1:0] EV_BACK_LONG    = 3'd6;

   // One poll item
   typedef struct packed {
      logic              back_level;
      logic              select_level;
      logic [TIME_W-1:0] now_ms;
   } poll_type;

   // One result item
   typedef struct packed {
      logic               back_down;
      logic               select_down;
      logic [EVENT_W-1:0] event_code;
   } result_type;

   // Configuration values handed to the event logic
   typedef struct packed {
      logic [CSR_W-1:0] debounce_hold_ms;
      logic [CSR_W-1:0] long_press_ms;
   } csr_type;

endpackage

// ===== hw/rtl/btndb_in_stage.sv =====
// Input register stage: holds one poll item until the event logic takes it.
// Depends on btndb_pkg.
module btndb_in_stage import btndb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  poll_type in_poll,
   output logic     out_valid,
   input  logic     out_ready,
   output poll_type out_poll
);

   logic     valid_ff, valid_in;
   poll_type poll_ff, poll_in;
   logic     load;

   // Take a new item whenever the stage is empty or drains this cycle
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      poll_in  = poll_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
      if (load) begin
         poll_in = in_poll;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      poll_ff <= poll_in;
   end

   assign out_valid = valid_ff;
   assign out_poll  = poll_ff;

endmodule

// ===== hw/rtl/btndb_core.sv =====
// Debounce state and event decision for the select and back buttons.
// Depends on btndb_pkg.
module btndb_core import btndb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  poll_type   poll,
   input  csr_type    csr,
   output result_type result
);

   logic              sel_prev_ff, sel_prev_in;
   logic              back_prev_ff, back_prev_in;
   logic [TIME_W-1:0] last_edge_ff, last_edge_in;
   logic [TIME_W-1:0] sel_start_ff, sel_start_in;
   logic [TIME_W-1:0] back_start_ff, back_start_in;

   logic              hold_done;
   logic              sel_edge, back_edge;
   logic              take_sel, take_back;
   logic              edge_level;
   logic [TIME_W-1:0] press_start;
   logic [TIME_W-1:0] held_ms;
   logic              is_long;
   logic [EVENT_W-1:0] event_code;

   // Hold check: elapsed time since the last accepted edge, modulo 2^32
   assign hold_done = (poll.now_ms - last_edge_ff) >=
                      {{(TIME_W-CSR_W){1'b0}}, csr.debounce_hold_ms};

   // Select is served before back; one edge per item
   assign sel_edge  = poll.select_level != sel_prev_ff;
   assign back_edge = poll.back_level != back_prev_ff;
   assign take_sel  = hold_done && sel_edge;
   assign take_back = hold_done && !sel_edge && back_edge;

   // Held time of the button whose edge is taken
   assign edge_level  = take_sel ? poll.select_level : poll.back_level;
   assign press_start = take_sel ? sel_start_ff : back_start_ff;
   assign held_ms     = poll.now_ms - press_start;
   assign is_long     = held_ms > {{(TIME_W-CSR_W){1'b0}}, csr.long_press_ms};

   // Event code
   always_comb begin
      event_code = EV_NONE;
      if (take_sel) begin
         if (!edge_level) begin
            event_code = EV_SEL_PRESS;
         end else if (is_long) begin
            event_code = EV_SEL_LONG;
         end else begin
            event_code = EV_SEL_RELEASE;
         end
      end else if (take_back) begin
         if (!edge_level) begin
            event_code = EV_BACK_PRESS;
         end else if (is_long) begin
            event_code = EV_BACK_LONG;
         end else begin
            event_code = EV_BACK_RELEASE;
         end
      end
   end

   assign result.event_code  = event_code;
   assign result.select_down = !poll.select_level;
   assign result.back_down   = !poll.back_level;

   // State update for an accepted edge
   always_comb begin
      sel_prev_in   = sel_prev_ff;
      back_prev_in  = back_prev_ff;
      last_edge_in  = last_edge_ff;
      sel_start_in  = sel_start_ff;
      back_start_in = back_start_ff;
      if (fire && take_sel) begin
         last_edge_in = poll.now_ms;
         sel_prev_in  = poll.select_level;
         if (!poll.select_level) begin
            sel_start_in = poll.now_ms;
         end
      end else if (fire && take_back) begin
         last_edge_in = poll.now_ms;
         back_prev_in = poll.back_level;
         if (!poll.back_level) begin
            back_start_in = poll.now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_prev_ff   <= 1'b1;
         back_prev_ff  <= 1'b1;
         last_edge_ff  <= '0;
         sel_start_ff  <= '0;
         back_start_ff <= '0;
      end else begin
         sel_prev_ff   <= sel_prev_in;
         back_prev_ff  <= back_prev_in;
         last_edge_ff  <= last_edge_in;
         sel_start_ff  <= sel_start_in;
         back_start_ff <= back_start_in;
      end
   end

endmodule

// ===== hw/rtl/btndb_out_stage.sv =====
// Result register: holds one result item until the consumer takes it.
// Depends on btndb_pkg.
module btndb_out_stage import btndb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_result,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   // Load when empty or when the held item leaves this cycle
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (in_ready) begin
         valid_in  = in_valid;
         result_in = in_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// ===== hw/rtl/two_button_debounce_long_press_top.sv =====
// Top level of the two-button debounce and long-press detector.
// Depends on btndb_pkg, btndb_in_stage, btndb_core and btndb_out_stage.
//
// Each poll item (timestamp in ms plus two active-low button levels) gives
// exactly one result item: an event code and the current down levels. A poll
// passes an input register, the event decision, and a result register, and
// one poll is accepted every cycle while the consumer keeps up; the rate is
// set by the registered update of the shared debounce state. Configuration
// writes must go in while no poll is in flight; the block does not enforce
// this. Index 0 is the debounce hold (reset 50 ms), index 1 the long-press
// limit (reset 1000 ms).
module two_button_debounce_long_press_top import btndb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // Poll items
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [39:0]      req_tdata,  // now_ms[31:0], select_level[32], back_level[33]
   // Result items
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,  // event_code[2:0], select_down[3], back_down[4]
   // Configuration writes
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   poll_type   req_poll, core_poll;
   result_type core_result, rsp_result;
   csr_type    csr_ff, csr_in;
   logic       core_valid, core_ready, core_fire;

   // Configuration registers
   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE_HOLD: csr_in.debounce_hold_ms = csr_wdata;
            CSR_LONG_PRESS:    csr_in.long_press_ms    = csr_wdata;
            default:           csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.debounce_hold_ms <= DEBOUNCE_HOLD_RESET;
         csr_ff.long_press_ms    <= LONG_PRESS_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Unpack the poll item
   assign req_poll.now_ms       = req_tdata[TIME_W-1:0];
   assign req_poll.select_level = req_tdata[TIME_W];
   assign req_poll.back_level   = req_tdata[TIME_W+1];

   btndb_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_poll   (req_poll),
      .out_valid (core_valid),
      .out_ready (core_ready),
      .out_poll  (core_poll)
   );

   assign core_fire = core_valid && core_ready;

   btndb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (core_fire),
      .poll   (core_poll),
      .csr    (csr_ff),
      .result (core_result)
   );

   btndb_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (core_valid),
      .in_ready   (core_ready),
      .in_result  (core_result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_result)
   );

   // Pack the result item
   assign rsp_tdata = {3'b000, rsp_result};

   // A select press comes with select shown down, a back release or long with back up
   a_sel_press_down: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_result.event_code == EV_SEL_PRESS) |-> rsp_result.select_down)
      else $error("select press without select down");

   a_back_up: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_result.event_code == EV_BACK_RELEASE ||
                     rsp_result.event_code == EV_BACK_LONG) |-> !rsp_result.back_down)
      else $error("back release with back still down");

   // A full pipeline behind a stalled consumer must not take another poll
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      core_valid && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("poll accepted while pipeline is full");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for two_button_debounce_long_press_top: directed polls, then random poll runs.
// Results are checked against an in-bench event predictor. Depends on btndb_pkg and the RTL.
module tb import btndb_pkg::*; ();

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 7;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_OFF_AT    = 400;
   localparam int HOLD_OFF_LEN   = 300;
   localparam int SIDE_REQ       = 0;
   localparam int SIDE_RSP       = 1;

   // One row of the directed table; want is used only where typed is set
   typedef struct packed {
      logic [TIME_W-1:0] now;
      logic              sel;
      logic              bck;
      logic              typed;
      result_type        want;
   } poll_row_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [39:0]      req_tdata  = '0;  // now_ms[31:0], select_level[32], back_level[33]
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;        // event_code[2:0], select_down[3], back_down[4]
   logic             csr_wr_en  = 1'b0;
   logic             csr_index  = CSR_DEBOUNCE_HOLD;
   logic [CSR_W-1:0] csr_wdata  = '0;

   // Predictor copy of the block state and configuration
   logic [CSR_W-1:0]  hold_ms;
   logic [CSR_W-1:0]  long_ms;
   logic              sel_level_q;
   logic              back_level_q;
   logic [TIME_W-1:0] last_edge_ms;
   logic [TIME_W-1:0] sel_start_ms;
   logic [TIME_W-1:0] back_start_ms;

   result_type   due_results[$];
   int           error_count = 0;
   int           polls_sent  = 0;
   int           calm_left[2] = '{0, 0};
   int           stall_left  = 0;
   logic         rsp_hold_off = 1'b0;
   poll_row_type directed_rows[18];

   // Random poll generator: a button timeline that mostly moves forward
   logic [TIME_W-1:0] gen_now;
   logic              gen_sel;
   logic              gen_bck;

   two_button_debounce_long_press_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Event decision for one poll; advances the predictor state
   function automatic result_type debounce_event(logic [TIME_W-1:0] now, logic sel, logic bck);
      result_type        r;
      logic [TIME_W-1:0] since;
      logic [TIME_W-1:0] held;
      r.event_code  = EV_NONE;
      r.select_down = ~sel;
      r.back_down   = ~bck;
      since = now - last_edge_ms;
      if (since >= {16'b0, hold_ms}) begin
         // select edge wins, back edge stays pending
         if (sel != sel_level_q) begin
            last_edge_ms = now;
            sel_level_q  = sel;
            held = now - sel_start_ms;
            if (!sel) begin
               sel_start_ms = now;
               r.event_code = EV_SEL_PRESS;
            end else if (held > {16'b0, long_ms}) begin
               r.event_code = EV_SEL_LONG;
            end else begin
               r.event_code = EV_SEL_RELEASE;
            end
         end else if (bck != back_level_q) begin
            last_edge_ms = now;
            back_level_q = bck;
            held = now - back_start_ms;
            if (!bck) begin
               back_start_ms = now;
               r.event_code  = EV_BACK_PRESS;
            end else if (held > {16'b0, long_ms}) begin
               r.event_code = EV_BACK_LONG;
            end else begin
               r.event_code = EV_BACK_RELEASE;
            end
         end
      end
      return r;
   endfunction

   // Wait drawn per item, with occasional stretches of no idling
   function automatic int draw_gap(int side);
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm_left[side] = $urandom_range(10, 30);
      return $urandom_range(0, 14);
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Offer one poll item and queue its expected result on acceptance
   task automatic send_poll(logic [TIME_W-1:0] now, logic sel, logic bck,
                            logic typed, result_type want);
      int         gap;
      result_type predicted;
      gap = draw_gap(SIDE_REQ);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, bck, sel, now};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = debounce_event(now, sel, bck);
      due_results.push_back(typed ? want : predicted);
      polls_sent++;
   endtask

   // Random polls: mostly a plausible timeline, some noise items
   task automatic run_random(int count);
      int   r;
      int   lim;
      logic noise_sel;
      logic noise_bck;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 11) == 0) begin
            noise_sel = 1'($urandom_range(0, 1));
            noise_bck = 1'($urandom_range(0, 1));
            send_poll($urandom, noise_sel, noise_bck, 1'b0, '0);
         end else begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
               lim = int'(hold_ms) + int'(hold_ms) / 2 + 1;
               gen_now = gen_now + $urandom_range(0, lim);
            end else if (r < 7) begin
               lim = int'(long_ms) + int'(long_ms) / 2 + 1;
               gen_now = gen_now + $urandom_range(0, lim);
            end else if (r < 9) begin
               gen_now = gen_now + $urandom_range(0, 5);
            end else begin
               gen_now = gen_now + $urandom;
            end
            if ($urandom_range(0, 2) == 0) gen_sel = ~gen_sel;
            if ($urandom_range(0, 2) == 0) gen_bck = ~gen_bck;
            send_poll(gen_now, gen_sel, gen_bck, 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   // Settle the block, then write both registers
   task automatic configure(logic [CSR_W-1:0] hold, logic [CSR_W-1:0] long_limit);
      while (due_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DEBOUNCE_HOLD;
      csr_wdata <= hold;
      hold_ms = hold;
      @(posedge clock);
      csr_index <= CSR_LONG_PRESS;
      csr_wdata <= long_limit;
      long_ms = long_limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Result side: check each accepted item, then draw the next stall
   always @(posedge clock) begin
      logic       next_ready;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("result 0x%02h with nothing due", rsp_tdata));
            end else begin
               want = due_results.pop_front();
               if (rsp_tdata[2:0] != want.event_code)
                  report_mismatch($sformatf("event_code got %0d expected %0d",
                                            rsp_tdata[2:0], want.event_code));
               if (rsp_tdata[3] != want.select_down)
                  report_mismatch($sformatf("select_down got %0b expected %0b",
                                            rsp_tdata[3], want.select_down));
               if (rsp_tdata[4] != want.back_down)
                  report_mismatch($sformatf("back_down got %0b expected %0b",
                                            rsp_tdata[4], want.back_down));
            end
            stall_left = draw_gap(SIDE_RSP);
         end
         if (stall_left > 0) begin
            next_ready = 1'b0;
            stall_left--;
         end else begin
            next_ready = 1'b1;
         end
         if (rsp_hold_off) next_ready = 1'b0;
         rsp_tready <= next_ready;
      end
   end

   // Long receiver hold-off while polls keep coming
   initial begin : pressure
      wait (polls_sent >= HOLD_OFF_AT);
      @(posedge clock);
      rsp_hold_off <= 1'b1;
      repeat (HOLD_OFF_LEN) @(posedge clock);
      rsp_hold_off <= 1'b0;
   end

   // Ends the run when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : main
      poll_row_type row;
      hold_ms       = DEBOUNCE_HOLD_RESET;
      long_ms       = LONG_PRESS_RESET;
      sel_level_q   = 1'b1;
      back_level_q  = 1'b1;
      last_edge_ms  = '0;
      sel_start_ms  = '0;
      back_start_ms = '0;
      gen_now       = $urandom;
      gen_sel       = 1'b1;
      gen_bck       = 1'b1;

      // now, select, back, typed, {back_down, select_down, event_code}
      directed_rows = '{
         // right after reset: idle, then an early press inside the hold
         {32'd0,          1'b1, 1'b1, 1'b1, 1'b0, 1'b0, EV_NONE},
         {32'd10,         1'b0, 1'b1, 1'b1, 1'b0, 1'b1, EV_NONE},
         // both pressed at the hold boundary: select first
         {32'd50,         1'b0, 1'b0, 1'b1, 1'b1, 1'b1, EV_SEL_PRESS},
         {32'd60,         1'b0, 1'b0, 1'b0, 2'b00, EV_NONE},
         {32'd100,        1'b0, 1'b0, 1'b0, 2'b00, EV_NONE},
         // both released long after: two long presses in turn
         {32'd1200,       1'b1, 1'b1, 1'b0, 2'b00, EV_NONE},
         {32'd1250,       1'b1, 1'b1, 1'b0, 2'b00, EV_NONE},
         {32'd1300,       1'b0, 1'b1, 1'b0, 2'b00, EV_NONE},
         {32'd1350,       1'b1, 1'b1, 1'b0, 2'b00, EV_NONE},
         // held exactly the limit, then one past it
         {32'd1400,       1'b0, 1'b1, 1'b0, 2'b00, EV_NONE},
         {32'd2400,       1'b1, 1'b1, 1'b0, 2'b00, EV_NONE},
         {32'd2450,       1'b0, 1'b1, 1'b0, 2'b00, EV_NONE},
         {32'd3451,       1'b1, 1'b1, 1'b0, 2'b00, EV_NONE},
         // timestamp wrap, hold spanning the wrap
         {32'hFFFF_FFF0,  1'b0, 1'b1, 1'b0, 2'b00, EV_NONE},
         {32'h0000_0030,  1'b1, 1'b1, 1'b0, 2'b00, EV_NONE},
         {32'hFFFF_FFFF,  1'b1, 1'b0, 1'b0, 2'b00, EV_NONE},
         {32'h0000_0020,  1'b1, 1'b1, 1'b0, 2'b00, EV_NONE},
         {32'h0000_0031,  1'b1, 1'b1, 1'b0, 2'b00, EV_NONE}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < $size(directed_rows); i++) begin
         row = directed_rows[i];
         send_poll(row.now, row.sel, row.bck, row.typed, row.want);
      end
      run_random(150);

      // Settings: extremes, reset values, random ones
      configure('0, '0);
      run_random(128);
      configure('1, '1);
      run_random(128);
      configure(DEBOUNCE_HOLD_RESET, LONG_PRESS_RESET);
      run_random(128);
      configure(CSR_W'($urandom_range(0, 200)), CSR_W'($urandom_range(0, 3000)));
      run_random(128);
      configure('0, '1);
      run_random(128);
      configure('1, '0);
      run_random(128);
      configure(CSR_W'($urandom_range(1, 100)), CSR_W'($urandom_range(100, 2000)));
      run_random(128);

      // Drain, then wait for stray results
      while (due_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
